### rtl/assert_macros.svh
// Assertion macros for the RTL of the foot pad conditioner.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FPNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define FPNC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fpnc_pkg.sv
// Package of the foot pad navigation conditioner: widths, codes, result layout.
// No dependencies.
package fpnc_pkg;

  localparam int SampleBits = 7;
  localparam int RampMax    = 127;
  localparam int StepBits   = 16;
  localparam int GainBits   = 12;
  localparam int LevelBits  = 11;
  localparam int EnBits     = 2;
  localparam int RampBits   = $clog2(RampMax + 1);
  localparam int ProdBits   = SampleBits + GainBits;
  localparam int ShiftBits  = ProdBits - 8;
  localparam int LevelMax   = (1 << LevelBits) - 1;
  localparam int AddrBits   = 5;
  localparam int DataBits   = 32;
  localparam int InDataBits = ((SampleBits + 7) / 8) * 8;
  localparam int OutBits    = 4 + StepBits + RampBits + 1;
  localparam int OutDataBits = ((OutBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    DIR_W = 2'd0,
    DIR_E = 2'd1,
    DIR_N = 2'd2,
    DIR_S = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    REG_GAIN_N  = 3'd0,
    REG_GAIN_S  = 3'd1,
    REG_GAIN_E  = 3'd2,
    REG_GAIN_W  = 3'd3,
    REG_PRESS   = 3'd4,
    REG_RELEASE = 3'd5,
    REG_BAND    = 3'd6,
    REG_ENABLE  = 3'd7
  } reg_e;

  typedef struct packed {
    logic [OutDataBits-OutBits-1:0] pad;
    logic                           ramp_changed;
    logic [RampBits-1:0]            ramp_value;
    logic [StepBits-1:0]            step_count;
    logic                           west_pressed;
    logic                           east_pressed;
    logic                           south_pressed;
    logic                           north_pressed;
  } res_t;

endpackage

### rtl/foot_pad_navigation_conditioner_core.sv
// Foot pad navigation conditioner: gain scaling, hysteresis, step counter, ramp.
// Depends on fpnc_pkg and assert_macros.svh.
//
//   port group   dir  payload
//   s_axis       in   tuser: kind[0], channel[2:1]; tdata: sample[6:0]
//   m_axis       out  tdata: N,S,E,W pressed[3:0], step[19:4], ramp[26:20], changed[27]
//   APB          in   eight registers at byte address 4*i
//
// One beat per cycle unless m_axis stalls; a result passes the input register, then the result register.
// The gain multiply sits in the input stage, the state update before the result register.
// Stalls on m_axis hold the result register; the input stage still takes one beat.
// Reset loads the register defaults, opens the step gate and clears all other pad, step and ramp state.
`include "assert_macros.svh"

module foot_pad_navigation_conditioner_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fpnc_pkg::InDataBits-1:0]      s_axis_tdata,   // sample
  input  logic [2:0]                           s_axis_tuser,   // kind, channel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fpnc_pkg::OutDataBits-1:0]     m_axis_tdata,   // N, S, E, W, step, ramp, changed
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpnc_pkg::AddrBits-1:0]        paddr,
  input  logic [fpnc_pkg::DataBits-1:0]        pwdata,
  output logic [fpnc_pkg::DataBits-1:0]        prdata,
  output logic                                 pready
);
  import fpnc_pkg::*;

  localparam logic signed [StepBits-1:0] StepLimit = {1'b0, {(StepBits-1){1'b1}}};

  logic [GainBits-1:0]  gain_n_q, gain_s_q, gain_e_q, gain_w_q;
  logic [LevelBits-1:0] press_q, release_q, band_q;
  logic [EnBits-1:0]    en_q;
  reg_e                 waddr;

  logic                 in_vld_q, in_tick_q;
  dir_e                 in_ch_q;
  logic [LevelBits-1:0] in_lvl_q;

  logic [LevelBits-1:0] lvl_q [4];
  logic [LevelBits-1:0] lvl_d [4];
  logic [3:0]           prs_q, prs_d;
  logic                 gate_q, gate_d;
  logic signed [StepBits-1:0] step_q, step_d;
  logic [RampBits-1:0]  ramp_q, ramp_d;
  logic                 up_q, up_d, run_q, run_d, emit_q, emit_d, chg_d;
  logic signed [LevelBits+1:0] diff_ns, band_s;

  logic                 res_vld_q;
  res_t                 res_q, res_d;

  logic                 s_acc, adv;
  dir_e                 s_ch;
  logic [GainBits-1:0]  s_gain;
  logic [ProdBits-1:0]  s_prod;
  logic [ShiftBits-1:0] s_shift;
  logic [LevelBits-1:0] s_lvl;

  // APB
  assign pready = 1'b1;
  assign waddr  = reg_e'(paddr[AddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_n_q  <= GainBits'(282);
      gain_s_q  <= GainBits'(282);
      gain_e_q  <= GainBits'(256);
      gain_w_q  <= GainBits'(256);
      press_q   <= LevelBits'(10);
      release_q <= LevelBits'(5);
      band_q    <= '0;
      en_q      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (waddr)
        REG_GAIN_N:  gain_n_q  <= pwdata[GainBits-1:0];
        REG_GAIN_S:  gain_s_q  <= pwdata[GainBits-1:0];
        REG_GAIN_E:  gain_e_q  <= pwdata[GainBits-1:0];
        REG_GAIN_W:  gain_w_q  <= pwdata[GainBits-1:0];
        REG_PRESS:   press_q   <= pwdata[LevelBits-1:0];
        REG_RELEASE: release_q <= pwdata[LevelBits-1:0];
        REG_BAND:    band_q    <= pwdata[LevelBits-1:0];
        REG_ENABLE:  en_q      <= pwdata[EnBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (waddr)
      REG_GAIN_N:  prdata = DataBits'(gain_n_q);
      REG_GAIN_S:  prdata = DataBits'(gain_s_q);
      REG_GAIN_E:  prdata = DataBits'(gain_e_q);
      REG_GAIN_W:  prdata = DataBits'(gain_w_q);
      REG_PRESS:   prdata = DataBits'(press_q);
      REG_RELEASE: prdata = DataBits'(release_q);
      REG_BAND:    prdata = DataBits'(band_q);
      REG_ENABLE:  prdata = DataBits'(en_q);
      default:     prdata = '0;
    endcase
  end

  // Input stage: scale the sample
  assign adv           = in_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_ch          = dir_e'(s_axis_tuser[2:1]);

  always_comb begin
    unique case (s_ch)
      DIR_W:   s_gain = gain_w_q;
      DIR_E:   s_gain = gain_e_q;
      DIR_N:   s_gain = gain_n_q;
      default: s_gain = gain_s_q;
    endcase
    s_prod  = ProdBits'(s_axis_tdata[SampleBits-1:0]) * ProdBits'(s_gain);
    s_shift = s_prod[ProdBits-1:8];
    if (ShiftBits'(s_shift) > ShiftBits'(LevelMax)) begin
      s_lvl = LevelBits'(LevelMax);
    end else begin
      s_lvl = s_shift[LevelBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_tick_q <= s_axis_tuser[0];
      in_ch_q   <= s_ch;
      in_lvl_q  <= s_lvl;
    end
  end

  // State update
  always_comb begin
    lvl_d   = lvl_q;
    prs_d   = prs_q;
    gate_d  = gate_q;
    step_d  = step_q;
    ramp_d  = ramp_q;
    up_d    = up_q;
    run_d   = run_q;
    emit_d  = emit_q;
    chg_d   = 1'b0;
    diff_ns = '0;
    band_s  = '0;
    if (!in_tick_q) begin
      lvl_d[in_ch_q] = in_lvl_q;
      for (int d = 0; d < 4; d++) begin
        if (lvl_d[d] > press_q && !prs_q[d]) begin
          prs_d[d] = 1'b1;
        end else if (lvl_d[d] < release_q && prs_q[d]) begin
          prs_d[d] = 1'b0;
        end
      end
      if (!prs_d[DIR_N] && !prs_d[DIR_S]) begin
        gate_d = 1'b1;
      end
      if (en_q[0]) begin
        if (prs_d[DIR_N] && gate_d) begin
          gate_d = 1'b0;
          if (step_q < StepLimit) begin
            step_d = step_q + StepBits'(1);
          end
        end else if (prs_d[DIR_S] && gate_d) begin
          gate_d = 1'b0;
          if (step_q > -StepLimit) begin
            step_d = step_q - StepBits'(1);
          end
        end
      end
      diff_ns = signed'({2'b00, lvl_d[DIR_N]}) - signed'({2'b00, lvl_d[DIR_S]});
      band_s  = signed'({2'b00, band_q});
      if (en_q[1]) begin
        if (prs_d[DIR_N] || prs_d[DIR_S]) begin
          if (diff_ns > band_s) begin
            up_d  = 1'b1;
            run_d = 1'b1;
          end else if (-diff_ns > band_s) begin
            up_d  = 1'b0;
            run_d = 1'b1;
          end else begin
            run_d = 1'b0;
          end
        end else begin
          run_d = 1'b0;
        end
      end
    end else if (run_q) begin
      if (up_q && ramp_q < RampBits'(RampMax)) begin
        ramp_d = ramp_q + RampBits'(1);
      end else if (!up_q && ramp_q != '0) begin
        ramp_d = ramp_q - RampBits'(1);
      end
      if (!emit_q || ramp_d != ramp_q) begin
        chg_d  = 1'b1;
        emit_d = 1'b1;
      end
    end
    res_d               = '0;
    res_d.north_pressed = prs_d[DIR_N];
    res_d.south_pressed = prs_d[DIR_S];
    res_d.east_pressed  = prs_d[DIR_E];
    res_d.west_pressed  = prs_d[DIR_W];
    res_d.step_count    = step_d;
    res_d.ramp_value    = ramp_d;
    res_d.ramp_changed  = chg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 4; d++) begin
        lvl_q[d] <= '0;
      end
      prs_q  <= '0;
      gate_q <= 1'b1;
      step_q <= '0;
      ramp_q <= '0;
      up_q   <= 1'b0;
      run_q  <= 1'b0;
      emit_q <= 1'b0;
    end else if (adv) begin
      lvl_q  <= lvl_d;
      prs_q  <= prs_d;
      gate_q <= gate_d;
      step_q <= step_d;
      ramp_q <= ramp_d;
      up_q   <= up_d;
      run_q  <= run_d;
      emit_q <= emit_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;

  `FPNC_ASSERT(a_step_in_range, step_q >= -StepLimit, "step position below limit")
  `FPNC_ASSERT(a_ramp_in_range, ramp_q <= RampBits'(RampMax), "ramp above maximum")
  `FPNC_ASSERT(a_gate_closed, gate_q || prs_q[DIR_N] || prs_q[DIR_S], "gate closed while released")
  `FPNC_ASSERT_NEXT(a_idle_tick, adv && in_tick_q && !run_q, !res_q.ramp_changed, "stopped tick flagged change")

endmodule

### bench/tb_foot_pad_navigation_conditioner_core.sv
// Self-checking bench for foot_pad_navigation_conditioner_core: drives sample/tick beats and
// APB register writes, predicts every result beat and compares it field by field.
// Depends on fpnc_pkg and the core RTL only.
module tb_foot_pad_navigation_conditioner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fpnc_pkg::*;

  localparam bit KIND_SAMPLE = 1'b0;
  localparam bit KIND_TICK   = 1'b1;
  localparam int EN_STEP     = 0;
  localparam int EN_RAMP     = 1;
  localparam int StepLimit   = (1 << (StepBits - 1)) - 1;
  localparam int MaxShown    = 10;

  class pad_result_tracker;
    bit [GainBits-1:0]  gain [4];
    bit [LevelBits-1:0] press_lvl, release_lvl, band;
    bit [EnBits-1:0]    enable;
    bit [LevelBits-1:0] level [4];
    bit                 pressed [4];
    bit                 gate_open;
    int                 step_pos;
    int                 ramp_pos;
    bit                 ramp_up, ramp_run, ramp_seen;
    res_t               pending [$];
    int                 failures, items, beats, ramp_changes;
    int                 step_hi, step_lo, ramp_hi;

    function new();
      gain[DIR_N] = 282;
      gain[DIR_S] = 282;
      gain[DIR_E] = 256;
      gain[DIR_W] = 256;
      press_lvl   = 10;
      release_lvl = 5;
      band        = 0;
      enable      = 0;
      for (int d = 0; d < 4; d++) begin
        level[d]   = 0;
        pressed[d] = 1'b0;
      end
      gate_open = 1'b1;
      step_pos  = 0;
      ramp_pos  = 0;
      ramp_up   = 1'b0;
      ramp_run  = 1'b0;
      ramp_seen = 1'b0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= MaxShown) $display("%s", msg);
    endfunction

    function void set_reg(reg_e idx, bit [DataBits-1:0] value);
      case (idx)
        REG_GAIN_N:  gain[DIR_N] = value[GainBits-1:0];
        REG_GAIN_S:  gain[DIR_S] = value[GainBits-1:0];
        REG_GAIN_E:  gain[DIR_E] = value[GainBits-1:0];
        REG_GAIN_W:  gain[DIR_W] = value[GainBits-1:0];
        REG_PRESS:   press_lvl   = value[LevelBits-1:0];
        REG_RELEASE: release_lvl = value[LevelBits-1:0];
        REG_BAND:    band        = value[LevelBits-1:0];
        default:     enable      = value[EnBits-1:0];
      endcase
    endfunction

    function void take_item(bit kind, dir_e ch, bit [SampleBits-1:0] smp);
      int   lvl;
      int   diff;
      int   prev;
      bit   changed;
      res_t r;
      changed = 1'b0;
      items++;
      if (kind == KIND_SAMPLE) begin
        lvl = (int'(smp) * int'(gain[ch])) >>> 8;
        level[ch] = (lvl > LevelMax) ? LevelMax[LevelBits-1:0] : lvl[LevelBits-1:0];
        for (int d = 0; d < 4; d++) begin
          if (level[d] > press_lvl && !pressed[d]) pressed[d] = 1'b1;
          else if (level[d] < release_lvl && pressed[d]) pressed[d] = 1'b0;
        end
        if (!pressed[DIR_N] && !pressed[DIR_S]) gate_open = 1'b1;
        if (enable[EN_STEP]) begin
          if (pressed[DIR_N] && gate_open) begin
            gate_open = 1'b0;
            if (step_pos < StepLimit) step_pos++;
          end else if (pressed[DIR_S] && gate_open) begin
            gate_open = 1'b0;
            if (step_pos > -StepLimit) step_pos--;
          end
        end
        if (enable[EN_RAMP]) begin
          diff = int'(level[DIR_N]) - int'(level[DIR_S]);
          if (pressed[DIR_N] || pressed[DIR_S]) begin
            if (diff > int'(band)) begin
              ramp_up  = 1'b1;
              ramp_run = 1'b1;
            end else if (-diff > int'(band)) begin
              ramp_up  = 1'b0;
              ramp_run = 1'b1;
            end else begin
              ramp_run = 1'b0;
            end
          end else begin
            ramp_run = 1'b0;
          end
        end
      end else if (ramp_run) begin
        prev = ramp_pos;
        if (ramp_up && ramp_pos < RampMax) ramp_pos++;
        else if (!ramp_up && ramp_pos > 0) ramp_pos--;
        if (!ramp_seen || ramp_pos != prev) begin
          changed   = 1'b1;
          ramp_seen = 1'b1;
          ramp_changes++;
        end
      end
      if (step_pos > step_hi) step_hi = step_pos;
      if (step_pos < step_lo) step_lo = step_pos;
      if (ramp_pos > ramp_hi) ramp_hi = ramp_pos;
      r = '0;
      r.north_pressed = pressed[DIR_N];
      r.south_pressed = pressed[DIR_S];
      r.east_pressed  = pressed[DIR_E];
      r.west_pressed  = pressed[DIR_W];
      r.step_count    = step_pos[StepBits-1:0];
      r.ramp_value    = ramp_pos[RampBits-1:0];
      r.ramp_changed  = changed;
      pending.push_back(r);
    endfunction

    function void check_beat(logic [OutDataBits-1:0] data);
      res_t got;
      res_t want;
      bit   bad;
      got = res_t'(data);
      beats++;
      if (pending.size() == 0) begin
        note_failure($sformatf("unexpected result beat %h", data));
        return;
      end
      want = pending.pop_front();
      bad = (got.north_pressed !== want.north_pressed) ||
            (got.south_pressed !== want.south_pressed) ||
            (got.east_pressed  !== want.east_pressed)  ||
            (got.west_pressed  !== want.west_pressed)  ||
            (got.step_count    !== want.step_count)    ||
            (got.ramp_value    !== want.ramp_value)    ||
            (got.ramp_changed  !== want.ramp_changed);
      if (bad)
        note_failure({
          $sformatf("beat %0d: exp N%b S%b E%b W%b step %0d ramp %0d chg %b, ",
                    beats, want.north_pressed, want.south_pressed, want.east_pressed,
                    want.west_pressed, $signed(want.step_count), want.ramp_value,
                    want.ramp_changed),
          $sformatf("got N%b S%b E%b W%b step %0d ramp %0d chg %b",
                    got.north_pressed, got.south_pressed, got.east_pressed,
                    got.west_pressed, $signed(got.step_count), got.ramp_value,
                    got.ramp_changed)});
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;  // sample
  logic [2:0]             s_axis_tuser = '0;  // kind, channel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;       // N, S, E, W, step, ramp, changed, pad
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [AddrBits-1:0]    paddr = '0;
  logic [DataBits-1:0]    pwdata = '0;
  logic [DataBits-1:0]    prdata;
  logic                   pready;

  pad_result_tracker tracker = new();
  bit [DataBits-1:0] cfg [8];
  int send_idle_pct = 21;
  int recv_idle_pct = 64;
  int send_calm = 0;
  int recv_calm = 0;

  foot_pad_navigation_conditioner_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (recv_calm > 0) begin
      recv_calm--;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(99) < 2) begin
      recv_calm = $urandom_range(10, 40);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_beat(m_axis_tdata);
  end

  initial begin
    #20_000_000;
    $display("foot_pad_navigation_conditioner_core: mismatch");
    $finish;
  end

  function automatic bit [DataBits-1:0] reg_mask(reg_e idx);
    case (idx)
      REG_GAIN_N, REG_GAIN_S, REG_GAIN_E, REG_GAIN_W: return (1 << GainBits) - 1;
      REG_PRESS, REG_RELEASE, REG_BAND:               return (1 << LevelBits) - 1;
      default:                                        return (1 << EnBits) - 1;
    endcase
  endfunction

  task automatic push_item(input bit kind, input dir_e ch, input bit [SampleBits-1:0] smp);
    int gap;
    gap = 0;
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(99) < 2) send_calm = $urandom_range(10, 40);
    else if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ch, kind};
    s_axis_tdata  <= InDataBits'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_item(kind, ch, smp);
  endtask

  task automatic push_tick();
    push_item(KIND_TICK, dir_e'($urandom_range(3)), $urandom_range(127));
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (tracker.pending.size() != 0) begin
      @(posedge clk_i);
      guard++;
      if (guard > 20000) begin
        $display("foot_pad_navigation_conditioner_core: mismatch");
        $finish;
      end
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic write_reg(input reg_e idx, input bit [DataBits-1:0] value);
    bit [DataBits-1:0] word;
    word = value & reg_mask(idx);
    if ($urandom_range(1)) word |= $urandom() & ~reg_mask(idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, word);
    // read back in the following transfer
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (word & reg_mask(idx)))
      tracker.note_failure($sformatf("register %s: exp %h, read %h", idx.name(),
                                     word & reg_mask(idx), prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings();
    for (int i = 0; i < 8; i++) write_reg(reg_e'(i), cfg[i]);
  endtask

  task automatic choose_settings(input int p);
    for (int i = 0; i < 4; i++) cfg[i] = $urandom_range(128, 1024);
    cfg[REG_PRESS]   = $urandom_range(4, 200);
    cfg[REG_RELEASE] = $urandom_range(0, cfg[REG_PRESS]);
    cfg[REG_BAND]    = $urandom_range(0, 64);
    cfg[REG_ENABLE]  = 3;
    case (p)
      1: begin
        cfg[REG_GAIN_N]  = 4095;
        cfg[REG_GAIN_S]  = 0;
        cfg[REG_GAIN_E]  = 4095;
        cfg[REG_GAIN_W]  = 1;
        cfg[REG_PRESS]   = 0;
        cfg[REG_RELEASE] = 0;
        cfg[REG_BAND]    = 0;
      end
      2: begin
        for (int i = 0; i < 4; i++) cfg[i] = 4095;
        cfg[REG_PRESS]   = 2047;
        cfg[REG_RELEASE] = 2047;
        cfg[REG_BAND]    = 2047;
      end
      3: begin
        cfg[REG_PRESS]   = 0;
        cfg[REG_RELEASE] = 2047;
        cfg[REG_BAND]    = $urandom_range(0, 300);
      end
      4: cfg[REG_ENABLE] = $urandom_range(1, 2);
      5: cfg[REG_ENABLE] = 0;
      default: ;
    endcase
  endtask

  task automatic run_random_items(input int count);
    int   done;
    int   pick;
    int   n;
    dir_e d;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // press on one side, maybe load the other, tick, then let go
        d = $urandom_range(1) ? DIR_N : DIR_S;
        push_item(KIND_SAMPLE, d, $urandom_range(1) ? 127 : $urandom_range(127));
        done++;
        if ($urandom_range(1)) begin
          push_item(KIND_SAMPLE, (d == DIR_N) ? DIR_S : DIR_N, $urandom_range(127));
          done++;
        end
        n = $urandom_range(0, 12);
        repeat (n) push_tick();
        done += n;
        push_item(KIND_SAMPLE, d, ($urandom_range(3) == 0) ? $urandom_range(127)
                                                            : $urandom_range(0, 4));
        done++;
      end else if (pick < 75) begin
        d = $urandom_range(1) ? DIR_E : DIR_W;
        push_item(KIND_SAMPLE, d, $urandom_range(1) ? 127 : $urandom_range(127));
        done++;
        if ($urandom_range(1)) begin
          push_item(KIND_SAMPLE, d, $urandom_range(127));
          done++;
        end
        push_item(KIND_SAMPLE, d, $urandom_range(0, 4));
        done++;
      end else if (pick < 88) begin
        n = $urandom_range(1, 20);
        repeat (n) push_tick();
        done += n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_item($urandom_range(1), dir_e'($urandom_range(3)), $urandom_range(127));
        done += n;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings first, step disabled but gate still reopens
    push_item(KIND_TICK, DIR_W, 0);
    push_item(KIND_SAMPLE, DIR_N, 127);
    push_item(KIND_SAMPLE, DIR_N, 0);
    pause_until_drained();
    cfg[REG_GAIN_N] = 282;
    cfg[REG_GAIN_S] = 282;
    cfg[REG_GAIN_E] = 256;
    cfg[REG_GAIN_W] = 256;
    cfg[REG_PRESS]   = 10;
    cfg[REG_RELEASE] = 5;
    cfg[REG_BAND]    = 0;
    cfg[REG_ENABLE]  = 3;
    apply_settings();
    push_item(KIND_SAMPLE, DIR_W, 127);
    push_item(KIND_SAMPLE, DIR_W, 0);
    push_item(KIND_SAMPLE, DIR_E, 127);
    push_item(KIND_SAMPLE, DIR_E, 8);
    push_item(KIND_SAMPLE, DIR_E, 4);
    push_item(KIND_SAMPLE, DIR_N, 127);
    push_item(KIND_TICK, DIR_N, 127);
    push_item(KIND_SAMPLE, DIR_S, 127);
    push_item(KIND_TICK, DIR_S, 0);
    push_item(KIND_SAMPLE, DIR_N, 0);
    push_item(KIND_TICK, DIR_E, 85);
    push_item(KIND_TICK, DIR_W, 42);
    push_item(KIND_SAMPLE, DIR_S, 0);
    push_item(KIND_SAMPLE, DIR_S, 127);
    push_item(KIND_SAMPLE, DIR_S, 0);
    push_item(KIND_SAMPLE, DIR_N, 85);
    push_item(KIND_SAMPLE, DIR_N, 42);
    push_item(KIND_SAMPLE, DIR_N, 0);

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 21 : (p < 4) ? 64 : 0;
      recv_idle_pct = (p < 2) ? 64 : (p < 4) ? 21 : 0;
      pause_until_drained();
      choose_settings(p);
      apply_settings();
      run_random_items(42);
      pause_until_drained();
      run_random_items(42);
    end

    // sweep the ramp to both ends
    pause_until_drained();
    for (int i = 0; i < 4; i++) cfg[i] = 256;
    cfg[REG_PRESS]   = 10;
    cfg[REG_RELEASE] = 5;
    cfg[REG_BAND]    = 0;
    cfg[REG_ENABLE]  = 3;
    apply_settings();
    push_item(KIND_SAMPLE, DIR_N, 127);
    repeat (RampMax + 3) push_tick();
    push_item(KIND_SAMPLE, DIR_N, 0);
    push_item(KIND_SAMPLE, DIR_S, 127);
    repeat (RampMax + 3) push_tick();
    push_item(KIND_SAMPLE, DIR_S, 0);

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.pending.size() != 0)
      tracker.note_failure($sformatf("%0d results never arrived", tracker.pending.size()));
    $display("Run covered %0d input beats and %0d result beats over 8 register settings.",
             tracker.items, tracker.beats);
    $display("Step count spanned %0d..%0d, ramp peaked at %0d with %0d changes; %0d failures.",
             tracker.step_lo, tracker.step_hi, tracker.ramp_hi, tracker.ramp_changes,
             tracker.failures);
    if (tracker.failures == 0) begin
      $display("foot_pad_navigation_conditioner_core: match");
    end else begin
      $display("foot_pad_navigation_conditioner_core: mismatch");
    end
    $finish;
  end

endmodule
